FILE: rtl/core/cgmd_pkg.sv
// Package for the compass gradient max direction unit.
// Holds the direction codes and kernel count; depends on nothing else.
package cgmd_pkg;

  localparam int unsigned NUM_DIRS = 8;
  localparam int unsigned DIR_W    = 3;

  // Direction codes: compass angle in degrees divided by 45.
  localparam logic [DIR_W-1:0] DIR_0   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_90  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_135 = 3'd3;
  localparam logic [DIR_W-1:0] DIR_180 = 3'd4;
  localparam logic [DIR_W-1:0] DIR_225 = 3'd5;
  localparam logic [DIR_W-1:0] DIR_270 = 3'd6;
  localparam logic [DIR_W-1:0] DIR_315 = 3'd7;

endpackage

FILE: rtl/core/compass_gradient_max_direction_unit.sv
// Compass gradient max direction unit: eight-direction compass gradient edge detector.
// Takes one 3x3 window per transfer. Depends on cgmd_pkg.
//
// Usage:
//   The in_ channel carries one 3x3 pixel window per transfer, with border filling
//   already done upstream. The out_ channel returns one result per window: the
//   largest positive compass response (amplitude), its direction code (degrees / 45)
//   and, in out_tuser, a flag that is set when any response was positive. With no
//   positive response the result is amplitude 0, direction 0, flag 0.
//   Results leave straight from the stage 5 register, so out_tvalid and out_tdata are registered.
//   Throughput is one window per cycle: the work is spread over five register stages
//   (window sums, signed responses, pairwise compare, compare of pairs, final pick),
//   and a new window enters every cycle while the output side takes results.
//   Each stage has its own valid bit and moves forward whenever the stage after it is
//   empty or moving, so bubbles close up during a stall. When out_tready is held low,
//   the pipeline fills up and in_tready falls once all five stages hold a window;
//   nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) empties all stages; data registers are not cleared.
//   Ties between directions go to the earliest in the order 270, 315, 0, 45, 90, 135,
//   180, 225 degrees.
module compass_gradient_max_direction_unit #(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // From bit 0 up: win_top_left, win_top_mid, win_top_right, win_mid_left,
  // win_mid_mid, win_mid_right, win_bot_left, win_bot_mid, win_bot_right, zero fill.
  input  logic [((9*PIXEL_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // From bit 0 up: amplitude, direction_code, zero fill.
  output logic [((PIXEL_BITS+5+7)/8)*8-1:0]     out_tdata,
  // Bit 0: edge_found.
  output logic [0:0]                            out_tuser
);
  import cgmd_pkg::*;

  localparam int unsigned OUT_W = ((PIXEL_BITS+5+7)/8)*8;
  localparam int unsigned SUM_W = PIXEL_BITS + 2;  // unsigned weighted sum of three pixels (weights 1, 2, 1)
  localparam int unsigned RSP_W = PIXEL_BITS + 3;  // signed compass response

  // Window taps in raster order.
  logic [PIXEL_BITS-1:0] pix [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pix[k] = in_tdata[k*PIXEL_BITS +: PIXEL_BITS];
    end
  end

  // Weighted sum a + 2b + c of three pixels.
  function automatic logic [SUM_W-1:0] wsum(input logic [PIXEL_BITS-1:0] a,
                                            input logic [PIXEL_BITS-1:0] b,
                                            input logic [PIXEL_BITS-1:0] c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  // Stage 1: half-kernel sums. The eight kernels are four opposite pairs, so
  // four differences of these sums cover all of them.
  logic [SUM_W-1:0] s_top_r, s_bot_r, s_lft_r, s_rgt_r;
  logic [SUM_W-1:0] s_ntl_r, s_sbr_r, s_sbl_r, s_ntr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      s_top_r <= wsum(pix[0], pix[1], pix[2]);
      s_bot_r <= wsum(pix[6], pix[7], pix[8]);
      s_lft_r <= wsum(pix[0], pix[3], pix[6]);
      s_rgt_r <= wsum(pix[2], pix[5], pix[8]);
      s_ntl_r <= wsum(pix[1], pix[0], pix[3]);  // 2*top_left + top_mid + mid_left
      s_sbr_r <= wsum(pix[5], pix[8], pix[7]);  // 2*bot_right + mid_right + bot_mid
      s_sbl_r <= wsum(pix[3], pix[6], pix[7]);  // 2*bot_left + mid_left + bot_mid
      s_ntr_r <= wsum(pix[1], pix[2], pix[5]);  // 2*top_right + top_mid + mid_right
    end
  end

  // Stage 2: signed responses of the 270, 315, 0 and 45 degree kernels.
  logic signed [RSP_W-1:0] g270_r, g315_r, g0_r, g45_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      g270_r <= signed'({1'b0, s_top_r}) - signed'({1'b0, s_bot_r});
      g315_r <= signed'({1'b0, s_ntl_r}) - signed'({1'b0, s_sbr_r});
      g0_r   <= signed'({1'b0, s_lft_r}) - signed'({1'b0, s_rgt_r});
      g45_r  <= signed'({1'b0, s_sbl_r}) - signed'({1'b0, s_ntr_r});
    end
  end

  // Candidates in check order; the last four are negations of the first four.
  logic signed [RSP_W-1:0] cand     [NUM_DIRS];
  logic [DIR_W-1:0]        cand_dir [NUM_DIRS];

  always_comb begin
    cand[0] = g270_r;   cand_dir[0] = DIR_270;
    cand[1] = g315_r;   cand_dir[1] = DIR_315;
    cand[2] = g0_r;     cand_dir[2] = DIR_0;
    cand[3] = g45_r;    cand_dir[3] = DIR_45;
    cand[4] = -g270_r;  cand_dir[4] = DIR_90;
    cand[5] = -g315_r;  cand_dir[5] = DIR_135;
    cand[6] = -g0_r;    cand_dir[6] = DIR_180;
    cand[7] = -g45_r;   cand_dir[7] = DIR_225;
  end

  // Stage 3: winners of adjacent pairs. The later one wins only when strictly
  // greater, which keeps the earliest direction on a tie.
  logic signed [RSP_W-1:0] w3_r   [4];
  logic [DIR_W-1:0]        w3_d_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      for (int k = 0; k < 4; k++) begin
        if (cand[2*k+1] > cand[2*k]) begin
          w3_r[k]   <= cand[2*k+1];
          w3_d_r[k] <= cand_dir[2*k+1];
        end else begin
          w3_r[k]   <= cand[2*k];
          w3_d_r[k] <= cand_dir[2*k];
        end
      end
    end
  end

  // Stage 4: winners of adjacent pair winners.
  logic signed [RSP_W-1:0] w4_r   [2];
  logic [DIR_W-1:0]        w4_d_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      for (int k = 0; k < 2; k++) begin
        if (w3_r[2*k+1] > w3_r[2*k]) begin
          w4_r[k]   <= w3_r[2*k+1];
          w4_d_r[k] <= w3_d_r[2*k+1];
        end else begin
          w4_r[k]   <= w3_r[2*k];
          w4_d_r[k] <= w3_d_r[2*k];
        end
      end
    end
  end

  // Stage 5: final pick and the positive test; this is the output register.
  logic signed [RSP_W-1:0] best;
  logic [DIR_W-1:0]        best_dir;
  logic [SUM_W-1:0]        amp_r;
  logic [DIR_W-1:0]        dir_r;
  logic                    found_r;

  always_comb begin
    if (w4_r[1] > w4_r[0]) begin
      best     = w4_r[1];
      best_dir = w4_d_r[1];
    end else begin
      best     = w4_r[0];
      best_dir = w4_d_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      if (best > signed'(RSP_W'(0))) begin
        amp_r   <= best[SUM_W-1:0];
        dir_r   <= best_dir;
        found_r <= 1'b1;
      end else begin
        amp_r   <= '0;
        dir_r   <= DIR_0;
        found_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = v5_r;
  assign out_tdata    = OUT_W'({dir_r, amp_r});
  assign out_tuser[0] = found_r;

`ifndef SYNTH
  // A result with no edge carries a zero amplitude and direction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !found_r) |-> (amp_r == '0 && dir_r == DIR_0))
    else $error("no-edge result with nonzero amplitude or direction");

  // An edge always comes with a positive amplitude.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && found_r) |-> (amp_r != '0))
    else $error("edge flagged with zero amplitude");

  // No response can exceed four times the largest pixel.
  assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> ({1'b0, amp_r} <= (SUM_W+1)'(4 * ((1 << PIXEL_BITS) - 1))))
    else $error("amplitude above the largest possible response");

  // Input is held off only when every stage is full and the output is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready))
    else $error("input stalled while the pipeline has room");

  // A stage that holds a window and is not allowed to move keeps it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !en4) |=> v4_r)
    else $error("stage four lost a window during a stall");
`endif

endmodule

FILE: bench/tb_compass_gradient_max_direction_unit.sv
// Self-checking testbench for compass_gradient_max_direction_unit.
// Drives 3x3 windows over in_, checks every out_ transfer against a predictor or a typed result.
// Depends on cgmd_pkg and the unit under test; needs no other file.
module tb_compass_gradient_max_direction_unit;
  import cgmd_pkg::*;

  localparam int unsigned PIXEL_BITS = 8;
  localparam int unsigned AMP_W      = PIXEL_BITS + 2;
  localparam int unsigned WIN_W      = ((9 * PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned RES_W      = ((PIXEL_BITS + 5 + 7) / 8) * 8;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

  // Random windows per idling phase; three phases give about 1100 in all.
  localparam int unsigned RANDOM_PER_PHASE = 367;
  // Cycles to wait after the last expected result has come back.
  localparam int unsigned DRAIN_CYCLES     = 12;

  // One result of the unit, field by field.
  typedef struct packed {
    logic [AMP_W-1:0] amplitude;
    logic [DIR_W-1:0] direction;
    logic             edge_found;
  } edge_result_t;

  // One row of the directed stimulus table. When has_typed is set the
  // result is written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [WIN_W-1:0] window;
    bit               has_typed;
    edge_result_t     typed;
  } window_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [WIN_W-1:0]    in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [RES_W-1:0]    out_tdata;
  logic [0:0]          out_tuser;

  // Travels alongside in_tdata so that the transfer monitor knows whether
  // the window in flight carries a hand-written result.
  bit                  window_has_typed;
  edge_result_t        window_typed;

  window_row_t         directed_rows[$];
  edge_result_t        pending_results[$];
  int unsigned         mismatches;
  int unsigned         sender_idle_pct;
  int unsigned         receiver_idle_pct;

  compass_gradient_max_direction_unit #(
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Packs a window in the order the in_tdata port lists its fields,
  // top-left pixel in the lowest bits.
  function automatic logic [WIN_W-1:0] pack_window(
    input logic [PIXEL_BITS-1:0] tl, input logic [PIXEL_BITS-1:0] tm,
    input logic [PIXEL_BITS-1:0] tr, input logic [PIXEL_BITS-1:0] ml,
    input logic [PIXEL_BITS-1:0] mm, input logic [PIXEL_BITS-1:0] mr,
    input logic [PIXEL_BITS-1:0] bl, input logic [PIXEL_BITS-1:0] bm,
    input logic [PIXEL_BITS-1:0] br);
    return WIN_W'({br, bm, bl, mr, mm, ml, tr, tm, tl});
  endfunction

  // Predicts the strongest compass edge of a window. The four kernels at
  // 90, 135, 180 and 225 degrees are the negations of those at 270, 315,
  // 0 and 45, so only four sums are formed. Kernels are visited in the
  // unit's priority order and a later one wins only with a strictly
  // larger, strictly positive response, so ties keep the earliest.
  function automatic edge_result_t strongest_edge(input logic [WIN_W-1:0] window);
    int           px[9];
    int           resp[8];
    int           best;
    edge_result_t res;
    for (int i = 0; i < 9; i++) begin
      px[i] = int'(window[i*PIXEL_BITS +: PIXEL_BITS]);
    end
    resp[0] = px[0] + 2*px[1] + px[2] - px[6] - 2*px[7] - px[8];   // 270
    resp[1] = 2*px[0] + px[1] + px[3] - px[5] - px[7] - 2*px[8];   // 315
    resp[2] = px[0] + 2*px[3] + px[6] - px[2] - 2*px[5] - px[8];   // 0
    resp[3] = px[3] + 2*px[6] + px[7] - px[1] - 2*px[2] - px[5];   // 45
    for (int k = 0; k < 4; k++) begin
      resp[k+4] = -resp[k];
    end
    best = 0;
    res  = '0;
    for (int k = 0; k < 8; k++) begin
      if (resp[k] > best) begin
        best           = resp[k];
        res.amplitude  = best[AMP_W-1:0];
        res.edge_found = 1'b1;
        case (k)
          0: res.direction = DIR_270;
          1: res.direction = DIR_315;
          2: res.direction = DIR_0;
          3: res.direction = DIR_45;
          4: res.direction = DIR_90;
          5: res.direction = DIR_135;
          6: res.direction = DIR_180;
          default: res.direction = DIR_225;
        endcase
      end
    end
    return res;
  endfunction

  // Draws a random window. Half are uniform noise; a quarter use only the
  // two extreme pixel values, which drives every response to its limits;
  // the rest are nearly flat patches, where responses are small, often
  // equal, and often none is positive.
  function automatic logic [WIN_W-1:0] random_window();
    logic [WIN_W-1:0] window;
    int unsigned      flavor;
    int               base;
    int               level;
    window = '0;
    flavor = $urandom_range(3);
    base   = int'($urandom_range(PIX_MAX));
    for (int i = 0; i < 9; i++) begin
      case (flavor)
        2: level = $urandom_range(1) ? int'(PIX_MAX) : 0;
        3: begin
          level = int'($urandom_range(6));
          level = base + level - 3;
          if (level < 0) level = 0;
          if (level > int'(PIX_MAX)) level = int'(PIX_MAX);
        end
        default: level = int'($urandom_range(PIX_MAX));
      endcase
      window[i*PIXEL_BITS +: PIXEL_BITS] = level[PIXEL_BITS-1:0];
    end
    return window;
  endfunction

  task automatic add_row(input logic [WIN_W-1:0] window, input bit has_typed,
                         input logic [AMP_W-1:0] amplitude,
                         input logic [DIR_W-1:0] direction, input logic edge_found);
    window_row_t row;
    row.window               = window;
    row.has_typed            = has_typed;
    row.typed.amplitude      = amplitude;
    row.typed.direction      = direction;
    row.typed.edge_found     = edge_found;
    directed_rows.push_back(row);
  endtask

  // Offers one window on the in_ channel and returns at the clock edge
  // where the transfer takes place. Before offering, the sender may idle
  // for a random number of cycles with in_tvalid low.
  task automatic send_window(input logic [WIN_W-1:0] window, input bit has_typed,
                             input edge_result_t typed);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid        <= 1'b1;
    in_tdata         <= window;
    window_has_typed <= has_typed;
    window_typed     <= typed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // The receiver stalls at random; the chance changes from phase to phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Transfer monitor. Signals are read at the rising edge, before any
  // update scheduled at that edge lands, so the values seen are the ones
  // the unit saw. The result side is handled first: an expectation
  // recorded at this edge can never be the one that leaves at this edge.
  always @(posedge clk) begin
    edge_result_t seen;
    edge_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.amplitude  = out_tdata[AMP_W-1:0];
        seen.direction  = out_tdata[AMP_W +: DIR_W];
        seen.edge_found = out_tuser[0];
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: amplitude %0d direction %0d edge_found %0b",
                 seen.amplitude, seen.direction, seen.edge_found);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (seen.amplitude !== want.amplitude) begin
            $error("amplitude: expected %0d, got %0d", want.amplitude, seen.amplitude);
            mismatches++;
          end
          if (seen.direction !== want.direction) begin
            $error("direction_code: expected %0d, got %0d", want.direction, seen.direction);
            mismatches++;
          end
          if (seen.edge_found !== want.edge_found) begin
            $error("edge_found: expected %0b, got %0b", want.edge_found, seen.edge_found);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(window_has_typed ? window_typed
                                                   : strongest_edge(in_tdata));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    edge_result_t no_result;
    no_result         = '0;
    mismatches        = 0;
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    window_has_typed  = 1'b0;
    window_typed      = '0;
    sender_idle_pct   = 9;
    receiver_idle_pct = 79;

    // Directed table. Flat windows give no positive response at all.
    add_row(pack_window(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, DIR_0, 0);
    add_row(pack_window(PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX, PIX_MAX,
                        PIX_MAX, PIX_MAX, PIX_MAX), 1, 0, DIR_0, 0);
    add_row(pack_window(1, 1, 1, 1, 1, 1, 1, 1, 1), 1, 0, DIR_0, 0);
    // The center pixel has weight zero in every kernel.
    add_row(pack_window(0, 0, 0, 0, PIX_MAX, 0, 0, 0, 0), 1, 0, DIR_0, 0);
    // A bright half-plane at full scale picks each of the eight directions
    // with the largest amplitude the unit can report.
    add_row(pack_window(PIX_MAX, PIX_MAX, PIX_MAX, 0, 0, 0, 0, 0, 0), 1, 1020, DIR_270, 1);
    add_row(pack_window(PIX_MAX, PIX_MAX, 0, PIX_MAX, 0, 0, 0, 0, 0), 1, 1020, DIR_315, 1);
    add_row(pack_window(PIX_MAX, 0, 0, PIX_MAX, 0, 0, PIX_MAX, 0, 0), 1, 1020, DIR_0, 1);
    add_row(pack_window(0, 0, 0, PIX_MAX, 0, 0, PIX_MAX, PIX_MAX, 0), 1, 1020, DIR_45, 1);
    add_row(pack_window(0, 0, 0, 0, 0, 0, PIX_MAX, PIX_MAX, PIX_MAX), 1, 1020, DIR_90, 1);
    add_row(pack_window(0, 0, 0, 0, 0, PIX_MAX, 0, PIX_MAX, PIX_MAX), 1, 1020, DIR_135, 1);
    add_row(pack_window(0, 0, PIX_MAX, 0, 0, PIX_MAX, 0, 0, PIX_MAX), 1, 1020, DIR_180, 1);
    add_row(pack_window(0, PIX_MAX, PIX_MAX, 0, 0, PIX_MAX, 0, 0, 0), 1, 1020, DIR_225, 1);
    // Three-way tie between 270, 315 and 225 degrees: the earliest wins.
    add_row(pack_window(PIX_MAX, 0, PIX_MAX, 0, 0, 0, 0, 0, 0), 1, 510, DIR_270, 1);
    // Remaining rows are left to the predictor.
    add_row(pack_window(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA),
            0, 0, DIR_0, 0);
    add_row(pack_window(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55),
            0, 0, DIR_0, 0);
    add_row(pack_window(8'h01, 8'hFE, 8'h7F, 8'h80, 8'h00, 8'hFF, 8'h10, 8'hEF, 8'h01),
            0, 0, DIR_0, 0);
    add_row(pack_window(0, 32, 64, 96, 128, 160, 192, 224, 255), 0, 0, DIR_0, 0);
    add_row(pack_window(255, 224, 192, 160, 128, 96, 64, 32, 0), 0, 0, DIR_0, 0);
    add_row(pack_window(0, 1, 0, 0, 0, 0, 0, 0, 0), 0, 0, DIR_0, 0);
    add_row(pack_window(0, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0, DIR_0, 0);
    add_row(pack_window(0, 0, 0, 0, 0, 0, PIX_MAX, 0, 0), 0, 0, DIR_0, 0);
    add_row(pack_window(17, 200, 3, 90, 45, 250, 128, 7, 66), 0, 0, DIR_0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_window(directed_rows[r].window, directed_rows[r].has_typed,
                  directed_rows[r].typed);
    end

    // Idling phases: sender seldom and receiver often, then the reverse,
    // then both sides flat out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct   = 9;
          receiver_idle_pct = 79;
        end
        1: begin
          sender_idle_pct   = 79;
          receiver_idle_pct = 9;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_window(random_window(), 0, no_result);
      end
    end

    in_tvalid <= 1'b0;
    receiver_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every item
  // meeting long sender gaps and long receiver stalls.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cgmd_pkg.sv
rtl/core/compass_gradient_max_direction_unit.sv
bench/tb_compass_gradient_max_direction_unit.sv
